### design/bfs_pkg.sv
// Shared constants, opcodes and controller/datapath interface types for the BFS unit.
`timescale 1ns / 1ps

package bfs_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 256;

	localparam int V_W     = $clog2(MAX_VERTICES);     // vertex id width
	localparam int VCNT_W  = $clog2(MAX_VERTICES + 1); // vertex count width
	localparam int E_W     = $clog2(MAX_EDGES);        // edge store index width
	localparam int ECNT_W  = $clog2(MAX_EDGES + 1);    // edge count width
	localparam int EDGE_W  = 2 * V_W;                  // packed {source, target}
	localparam int OP_W    = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD   = 2'd0,
		OP_RUN   = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DEQ,
		ST_FETCH,
		ST_EDGE
	} state_t;

	typedef struct packed {
		logic add_edge;    // store or drop an edge this cycle
		logic clear_graph; // empty edge store, clear error flag
		logic run_init;    // clear visited marks and queue, rewind counters
		logic start_push;  // mark and enqueue the current start vertex
		logic start_next;  // advance to the next start vertex
		logic deq_read;    // read the queue head
		logic deq_take;    // emit the head vertex and rewind the edge scan
		logic edge_scan;   // stream edges and enqueue unvisited targets
	} cmd_t;

	typedef struct packed {
		logic start_end;   // start vertex reached the vertex count
		logic start_seen;  // start vertex already visited
		logic queue_empty;
		logic edges_done;  // edge scan finished and drained
	} status_t;

endpackage

### design/bfs_ctrl.sv
// Sequencing state machine for edge insertion, clearing and breadth-first runs.
`timescale 1ns / 1ps

module bfs_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [bfs_pkg::OP_W-1:0]  opcode,
	input  bfs_pkg::status_t          status,
	output bfs_pkg::cmd_t             cmd,
	output logic                      busy
);

	bfs_pkg::state_t state_q, state_d;
	logic            accept;

	assign accept = start && (state_q == bfs_pkg::ST_IDLE);
	assign busy   = (state_q != bfs_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bfs_pkg::ST_IDLE: begin
				if (accept && opcode == bfs_pkg::OP_RUN) begin
					state_d = bfs_pkg::ST_START;
				end
			end
			bfs_pkg::ST_START: begin
				if (status.start_end) begin
					state_d = bfs_pkg::ST_IDLE;
				end else if (!status.start_seen) begin
					state_d = bfs_pkg::ST_DEQ;
				end
			end
			bfs_pkg::ST_DEQ: begin
				if (status.queue_empty) begin
					state_d = bfs_pkg::ST_START;
				end else begin
					state_d = bfs_pkg::ST_FETCH;
				end
			end
			bfs_pkg::ST_FETCH: begin
				state_d = bfs_pkg::ST_EDGE;
			end
			bfs_pkg::ST_EDGE: begin
				if (status.edges_done) begin
					state_d = bfs_pkg::ST_DEQ;
				end
			end
			default: begin
				state_d = bfs_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			bfs_pkg::ST_IDLE: begin
				cmd.add_edge    = accept && opcode == bfs_pkg::OP_ADD;
				cmd.clear_graph = accept && opcode == bfs_pkg::OP_CLEAR;
				cmd.run_init    = accept && opcode == bfs_pkg::OP_RUN;
			end
			bfs_pkg::ST_START: begin
				cmd.start_push = !status.start_end && !status.start_seen;
				cmd.start_next = !status.start_end && status.start_seen;
			end
			bfs_pkg::ST_DEQ: begin
				cmd.deq_read   = !status.queue_empty;
				cmd.start_next = status.queue_empty;
			end
			bfs_pkg::ST_FETCH: begin
				cmd.deq_take = 1'b1;
			end
			bfs_pkg::ST_EDGE: begin
				cmd.edge_scan = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### design/bfs_dp.sv
// Datapath: edge store, visited marks, vertex queue, counters and result registers.
`timescale 1ns / 1ps

module bfs_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [bfs_pkg::VCNT_W-1:0]  cfg_wr_data,
	input  logic [bfs_pkg::V_W-1:0]     from_vertex,
	input  logic [bfs_pkg::V_W-1:0]     to_vertex,
	input  bfs_pkg::cmd_t               cmd,
	output bfs_pkg::status_t            status,
	output logic                        valid,
	output logic [bfs_pkg::V_W-1:0]     vertex,
	output logic                        last,
	output logic                        error
);

	localparam logic [bfs_pkg::VCNT_W-1:0] VcntMax = bfs_pkg::VCNT_W'(bfs_pkg::MAX_VERTICES);
	localparam logic [bfs_pkg::ECNT_W-1:0] EcntMax = bfs_pkg::ECNT_W'(bfs_pkg::MAX_EDGES);

	logic [bfs_pkg::EDGE_W-1:0]   edge_mem [bfs_pkg::MAX_EDGES];
	logic [bfs_pkg::V_W-1:0]      queue_mem [bfs_pkg::MAX_VERTICES];

	logic [bfs_pkg::VCNT_W-1:0]   vcount_q;
	logic [bfs_pkg::ECNT_W-1:0]   held_q;
	logic                         dropped_q;
	logic [bfs_pkg::MAX_VERTICES-1:0] visited_q;
	logic [bfs_pkg::VCNT_W-1:0]   head_q;
	logic [bfs_pkg::VCNT_W-1:0]   tail_q;
	logic [bfs_pkg::VCNT_W-1:0]   start_q;
	logic [bfs_pkg::VCNT_W-1:0]   emit_q;
	logic [bfs_pkg::ECNT_W-1:0]   edge_k_q;
	logic [bfs_pkg::V_W-1:0]      cur_q;
	logic [bfs_pkg::V_W-1:0]      q_rd_s1;
	logic [bfs_pkg::EDGE_W-1:0]   edge_rd_s1;
	logic                         chk_valid_s1;
	logic                         valid_q;
	logic [bfs_pkg::V_W-1:0]      vertex_q;
	logic                         last_q;

	logic [bfs_pkg::VCNT_W-1:0]   n_eff;
	logic                         add_ok;
	logic                         edge_issue;
	logic [bfs_pkg::V_W-1:0]      chk_src;
	logic [bfs_pkg::V_W-1:0]      chk_tgt;
	logic                         chk_push;
	logic                         q_wr_en;
	logic [bfs_pkg::V_W-1:0]      q_wr_data;

	// saturate the configured count at the vertex capacity
	assign n_eff = (vcount_q > VcntMax) ? VcntMax : vcount_q;

	assign add_ok = ({1'b0, from_vertex} < n_eff) && ({1'b0, to_vertex} < n_eff)
		&& (held_q < EcntMax);

	assign edge_issue = cmd.edge_scan && (edge_k_q < held_q);

	assign chk_src  = edge_rd_s1[bfs_pkg::EDGE_W-1:bfs_pkg::V_W];
	assign chk_tgt  = edge_rd_s1[bfs_pkg::V_W-1:0];
	assign chk_push = cmd.edge_scan && chk_valid_s1 && (chk_src == cur_q)
		&& ({1'b0, chk_tgt} < n_eff) && !visited_q[chk_tgt];

	assign q_wr_en   = cmd.start_push || chk_push;
	assign q_wr_data = cmd.start_push ? start_q[bfs_pkg::V_W-1:0] : chk_tgt;

	assign status.start_end   = (start_q >= n_eff);
	assign status.start_seen  = visited_q[start_q[bfs_pkg::V_W-1:0]];
	assign status.queue_empty = (head_q == tail_q);
	assign status.edges_done  = !(edge_k_q < held_q) && !chk_valid_s1;

	// memories: no reset, reads registered
	always_ff @(posedge clk) begin
		if (cmd.add_edge && add_ok) begin
			edge_mem[held_q[bfs_pkg::E_W-1:0]] <= {from_vertex, to_vertex};
		end
		edge_rd_s1 <= edge_mem[edge_k_q[bfs_pkg::E_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (q_wr_en) begin
			queue_mem[tail_q[bfs_pkg::V_W-1:0]] <= q_wr_data;
		end
		if (cmd.deq_read) begin
			q_rd_s1 <= queue_mem[head_q[bfs_pkg::V_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.deq_take) begin
			cur_q    <= q_rd_s1;
			vertex_q <= q_rd_s1;
			last_q   <= ((emit_q + 1'b1) == n_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q     <= VcntMax;
			held_q       <= '0;
			dropped_q    <= 1'b0;
			visited_q    <= '0;
			head_q       <= '0;
			tail_q       <= '0;
			start_q      <= '0;
			emit_q       <= '0;
			edge_k_q     <= '0;
			chk_valid_s1 <= 1'b0;
			valid_q      <= 1'b0;
		end else begin
			valid_q      <= cmd.deq_take;
			chk_valid_s1 <= edge_issue;
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end
			if (cmd.add_edge) begin
				if (add_ok) begin
					held_q <= held_q + 1'b1;
				end else begin
					dropped_q <= 1'b1;
				end
			end
			if (cmd.clear_graph) begin
				held_q    <= '0;
				dropped_q <= 1'b0;
				visited_q <= '0;
				head_q    <= '0;
				tail_q    <= '0;
			end
			if (cmd.run_init) begin
				visited_q <= '0;
				head_q    <= '0;
				tail_q    <= '0;
				start_q   <= '0;
				emit_q    <= '0;
			end
			if (cmd.start_next) begin
				start_q <= start_q + 1'b1;
			end
			if (q_wr_en) begin
				visited_q[q_wr_data] <= 1'b1;
				tail_q               <= tail_q + 1'b1;
			end
			if (cmd.deq_take) begin
				head_q   <= head_q + 1'b1;
				emit_q   <= emit_q + 1'b1;
				edge_k_q <= '0;
			end else if (edge_issue) begin
				edge_k_q <= edge_k_q + 1'b1;
			end
		end
	end

	assign valid  = valid_q;
	assign vertex = vertex_q;
	assign last   = last_q;
	assign error  = dropped_q;

endmodule

### design/bfs_traversal_order_unit.sv
// Top level: directed graph store with breadth-first traversal order output.
//
//   channel   signals                                   direction  handshake
//   command   start, opcode, from_vertex, to_vertex     in         start && !busy
//   result    valid, vertex, last, error                out        valid strobe, one cycle
//   config    cfg_wr_en, cfg_wr_data (vertex_count)     in         cfg_wr_en
//
// Add-edge and clear commands complete in the cycle they transfer; busy stays low.
// During a run each dequeued vertex streams the whole edge store through its one read
// port, one edge a cycle.
// Reset empties the graph and sets the vertex count to 64; no clearing pass is needed.
// Results leave as one-cycle strobes; the receiver cannot stall them.
`timescale 1ns / 1ps

module bfs_traversal_order_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [bfs_pkg::OP_W-1:0]    opcode,
	input  logic [bfs_pkg::V_W-1:0]     from_vertex,
	input  logic [bfs_pkg::V_W-1:0]     to_vertex,
	input  logic                        cfg_wr_en,
	input  logic [bfs_pkg::VCNT_W-1:0]  cfg_wr_data,
	output logic                        valid,
	output logic [bfs_pkg::V_W-1:0]     vertex,
	output logic                        last,
	output logic                        error
);

	bfs_pkg::cmd_t    cmd;
	bfs_pkg::status_t status;

	bfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	bfs_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.from_vertex (from_vertex),
		.to_vertex   (to_vertex),
		.cmd         (cmd),
		.status      (status),
		.valid       (valid),
		.vertex      (vertex),
		.last        (last),
		.error       (error)
	);

endmodule
